// ===== hdl/hsfc_pkg.sv =====
// Package with shared types, constants and functions of the humidity sensor frame checker.
`timescale 1ns / 1ps

package hsfc_pkg;

	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	localparam logic [2:0] POS_TEMP_HI  = 3'd0;
	localparam logic [2:0] POS_TEMP_LO  = 3'd1;
	localparam logic [2:0] POS_TEMP_CRC = 3'd2;
	localparam logic [2:0] POS_HUM_HI   = 3'd3;
	localparam logic [2:0] POS_HUM_LO   = 3'd4;
	localparam logic [2:0] POS_HUM_CRC  = 3'd5;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TEMP_ERR = 2'd1;
	localparam logic [1:0] STATUS_HUM_ERR  = 2'd2;

	localparam logic [14:0] TEMP_SCALE  = 15'd17500;
	localparam logic [14:0] HUM_SCALE   = 15'd10000;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic [16:0] FULL_SCALE  = 17'd65535;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] temp_raw;
		logic [15:0] hum_raw;
	} job_t;

	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Floor division by 65535 for products below 17500 * 65535.
	function automatic logic [14:0] div_full_scale(input logic [30:0] x);
		logic [14:0] q0;
		logic [16:0] r;
		q0 = x[30:16];
		r = {1'b0, x[15:0]} + {2'b00, q0};
		return q0 + {14'd0, (r >= FULL_SCALE)};
	endfunction

endpackage

// ===== hdl/hsfc_front.sv =====
// Front end: tracks frame position, runs the CRC checks and queues a job per frame.
`timescale 1ns / 1ps

module hsfc_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    data_byte,
	input  logic          frame_start,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          q_full,
	output logic          push,
	output hsfc_pkg::job_t job
);
	import hsfc_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_raw_q;
	logic [7:0]  hum_hi_q;
	logic [7:0]  hum_lo_q;
	logic        tgood_q;
	logic [2:0]  pos_eff;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign pos_eff  = (frame_start || pos_q > POS_HUM_CRC) ? POS_TEMP_HI : pos_q;
	assign push     = accept && (pos_eff == POS_HUM_CRC);

	always_comb begin
		job.temp_raw = temp_raw_q;
		job.hum_raw  = {hum_hi_q, hum_lo_q};
		priority if (!tgood_q) begin
			job.status = STATUS_TEMP_ERR;
		end else if (crc_q != data_byte) begin
			job.status = STATUS_HUM_ERR;
		end else begin
			job.status = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_TEMP_HI;
			crc_q      <= CRC_INIT;
			temp_raw_q <= 16'd0;
			hum_hi_q   <= 8'd0;
			hum_lo_q   <= 8'd0;
			tgood_q    <= 1'b0;
		end else if (accept) begin
			pos_q <= (pos_eff == POS_HUM_CRC) ? POS_TEMP_HI : pos_eff + 3'd1;
			unique case (pos_eff)
				POS_TEMP_HI: begin
					temp_raw_q <= {data_byte, 8'd0};
					crc_q      <= crc_update(CRC_INIT, data_byte);
				end
				POS_TEMP_LO: begin
					temp_raw_q <= {temp_raw_q[15:8], data_byte};
					crc_q      <= crc_update(crc_q, data_byte);
				end
				POS_TEMP_CRC: begin
					tgood_q <= (crc_q == data_byte);
					crc_q   <= CRC_INIT;
				end
				POS_HUM_HI: begin
					hum_hi_q <= data_byte;
					crc_q    <= crc_update(CRC_INIT, data_byte);
				end
				POS_HUM_LO: begin
					hum_lo_q <= data_byte;
					crc_q    <= crc_update(crc_q, data_byte);
				end
				default: begin
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

endmodule

// ===== hdl/hsfc_queue.sv =====
// Two-entry queue of frame jobs between the front and back ends.
`timescale 1ns / 1ps

module hsfc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hsfc_pkg::job_t push_job,
	input  logic           pop,
	output logic           q_valid,
	output logic           q_full,
	output hsfc_pkg::job_t q_job
);
	import hsfc_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign q_valid = (count_q != 2'd0);
	assign q_full  = (count_q == 2'd2);
	assign q_job   = entry_q[rd_ptr_q];
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

// ===== hdl/hsfc_back.sv =====
// Back end: scales the raw words to hundredths (zero on a CRC error) and holds the result word for the consumer.
`timescale 1ns / 1ps

module hsfc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  hsfc_pkg::job_t     q_job,
	output logic               pop,
	output logic [1:0]         status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               out_valid,
	input  logic               out_ready
);
	import hsfc_pkg::*;

	logic        v_s1;
	logic [1:0]  status_s1;
	logic [30:0] temp_prod_s1;
	logic [30:0] hum_prod_s1;
	logic        v_s2;
	logic        adv1;
	logic        adv2;
	logic [14:0] temp_q15;
	logic [14:0] hum_q15;
	logic [15:0] temp_diff;

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign pop  = q_valid && adv1;
	assign out_valid = v_s2;

	assign temp_q15  = div_full_scale(temp_prod_s1);
	assign hum_q15   = div_full_scale(hum_prod_s1);
	assign temp_diff = {1'b0, temp_q15} - TEMP_OFFSET;

	always_ff @(posedge clk) begin
		if (adv1) begin
			status_s1    <= q_job.status;
			temp_prod_s1 <= {16'd0, TEMP_SCALE} * {15'd0, q_job.temp_raw};
			hum_prod_s1  <= {16'd0, HUM_SCALE} * {15'd0, q_job.hum_raw};
		end
		if (adv2 && v_s1) begin
			status <= status_s1;
			if (status_s1 == STATUS_OK) begin
				temperature_centi <= temp_diff[14:0];
				humidity_centi    <= hum_q15[13:0];
			end else begin
				temperature_centi <= 15'sd0;
				humidity_centi    <= 14'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= q_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

endmodule

// ===== hdl/humidity_sensor_frame_checker.sv =====
// Top level of the humidity sensor frame checker.
// Throughput: one byte word per cycle, limited only by consumer backpressure.
// After its sixth byte is taken, a frame's job is queued, then registered in the product stage and the output stage.
// The front end takes bytes while the two-entry job queue has room.
// Reset is asynchronous and active low; it clears frame position, CRC and all valid flags.
`timescale 1ns / 1ps

module humidity_sensor_frame_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic               frame_start,
	input  logic               in_valid,
	output logic               in_ready,
	output logic [1:0]         status,
	output logic signed [14:0] temperature_centi,
	output logic [13:0]        humidity_centi,
	output logic               out_valid,
	input  logic               out_ready
);
	import hsfc_pkg::*;

	logic push;
	logic pop;
	logic q_valid;
	logic q_full;
	job_t push_job;
	job_t q_job;

	hsfc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.frame_start (frame_start),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job)
	);

	hsfc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_full   (q_full),
		.q_job    (q_job)
	);

	hsfc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_job             (q_job),
		.pop               (pop),
		.status            (status),
		.temperature_centi (temperature_centi),
		.humidity_centi    (humidity_centi),
		.out_valid         (out_valid),
		.out_ready         (out_ready)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("Job pushed into a full queue.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != STATUS_OK) |->
			(temperature_centi == 15'sd0 && humidity_centi == 14'd0))
		else $error("Nonzero values on a CRC error result.");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STATUS_OK) |-> (humidity_centi <= 14'd10000))
		else $error("Humidity result out of range.");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("Pop from an empty queue.");

endmodule
